// ===== src/rc_serial_frame_decoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// rc serial frame decoder assertion macros
// immediate-antecedent and next-cycle property checks, clocked on clk
// ----------------------------------------------------------------------------
`ifndef RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH
`define RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define RSFD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsfd check failed");

// next-cycle implication
`define RSFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsfd check failed");

`else

`define RSFD_ASSERT_NOW(label, ante, cons)
`define RSFD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/rsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfd_pkg
// shared types and constants of the rc serial frame decoder
// ----------------------------------------------------------------------------
package rsfd_pkg;

  localparam int CHANNEL_BITS = 11;

  localparam logic [7:0] START_BYTE = 8'h0F;
  localparam logic [7:0] FRAME_LEN  = 8'd25;
  localparam logic [7:0] IDLE_MAX   = 8'hFF;
  localparam logic [7:0] IDLE_TICKS_RST = 8'd2;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic wr;
    logic shift;
  } frame_ctrl_t;

endpackage

// ===== src/rsfd_frame_buf.sv =====
// ----------------------------------------------------------------------------
// rsfd_frame_buf
// frame byte store with a channel shifter that yields one channel per step
// ----------------------------------------------------------------------------
module rsfd_frame_buf #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic                             clk,
  input  rsfd_pkg::frame_ctrl_t            ctrl,
  input  logic [$clog2(1 + (NUM_CHANNELS * rsfd_pkg::CHANNEL_BITS + 7) / 8)-1:0] wr_idx,
  input  logic [7:0]                       wr_data,
  output logic [7:0]                       first_byte,
  output logic [rsfd_pkg::CHANNEL_BITS-1:0] chan_bits
);

  localparam int FRAME_KEEP = 1 + (NUM_CHANNELS * rsfd_pkg::CHANNEL_BITS + 7) / 8;
  localparam int IDX_W      = $clog2(FRAME_KEEP);
  localparam int BITS_W     = (FRAME_KEEP - 1) * 8;

  logic [7:0]        first_byte_r;
  logic [BITS_W-1:0] payload_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr) begin
      if (wr_idx == '0) begin
        first_byte_r <= wr_data;
      end
      for (int i = 1; i < FRAME_KEEP; i++) begin
        if (wr_idx == IDX_W'(i)) begin
          payload_r[(i - 1) * 8 +: 8] <= wr_data;
        end
      end
    end else if (ctrl.shift) begin
      payload_r <= payload_r >> rsfd_pkg::CHANNEL_BITS;
    end
  end

  assign first_byte = first_byte_r;
  assign chan_bits  = payload_r[rsfd_pkg::CHANNEL_BITS-1:0];

endmodule

// ===== src/rc_serial_frame_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// rc_serial_frame_decoder_unit
// bytes, ticks and reads are handled when accepted; a frame-ending tick on a valid
// frame stalls the input while the frame unpacks, one channel per cycle through the
// shared frame shifter. read result is registered, in the cycle after the request
// synchronous active-low reset clears counters, channels and idle_ticks to 2
// ----------------------------------------------------------------------------
`include "rc_serial_frame_decoder_unit_assert.svh"

module rc_serial_frame_decoder_unit #(
  parameter int NUM_CHANNELS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_byte_value,
  input  logic [3:0]  in_channel_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_channel_value
);

  localparam int FRAME_KEEP = 1 + (NUM_CHANNELS * rsfd_pkg::CHANNEL_BITS + 7) / 8;
  localparam int IDX_W      = $clog2(FRAME_KEEP);
  localparam int CH_W       = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_UNPACK
  } state_t;

  state_t state_r, state_nxt;
  logic [7:0]  idle_ticks_r, idle_ticks_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [7:0]  idle_count_r, idle_count_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;
  logic [rsfd_pkg::CHANNEL_BITS-1:0] chan_store_r [NUM_CHANNELS];
  logic        out_valid_r, out_valid_nxt;
  logic [10:0] out_value_r, out_value_nxt;

  logic        accept;
  logic        frame_end;
  logic [7:0]  idle_inc;
  logic [3:0]  rd_idx;
  logic        rd_ok;
  rsfd_pkg::frame_ctrl_t fb_ctrl;
  logic [7:0]  first_byte;
  logic [rsfd_pkg::CHANNEL_BITS-1:0] chan_bits;

  assign in_stall = (state_r == ST_UNPACK) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign idle_inc = idle_count_r + 8'd1;
  assign frame_end = accept && (rsfd_pkg::cmd_t'(in_cmd) == rsfd_pkg::CMD_TICK) &&
                     (idle_count_r != rsfd_pkg::IDLE_MAX) && (idle_inc == idle_ticks_r);
  assign rd_idx   = in_channel_number - 4'd1;
  assign rd_ok    = (in_channel_number != 4'd0) &&
                    ({1'b0, in_channel_number} <= 5'(NUM_CHANNELS));

  rsfd_frame_buf #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_frame_buf (
    .clk        (clk),
    .ctrl       (fb_ctrl),
    .wr_idx     (byte_count_r[IDX_W-1:0]),
    .wr_data    (in_byte_value),
    .first_byte (first_byte),
    .chan_bits  (chan_bits)
  );

  always_comb begin
    state_nxt      = state_r;
    idle_ticks_nxt = cfg_wr_en ? cfg_wr_data : idle_ticks_r;
    byte_count_nxt = byte_count_r;
    idle_count_nxt = idle_count_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    fb_ctrl.wr     = 1'b0;
    fb_ctrl.shift  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (rsfd_pkg::cmd_t'(in_cmd))
            rsfd_pkg::CMD_BYTE: begin
              idle_count_nxt = 8'd0;
              fb_ctrl.wr     = byte_count_r < 8'(FRAME_KEEP);
              byte_count_nxt = byte_count_r + 8'd1;
            end
            rsfd_pkg::CMD_TICK: begin
              if (idle_count_r != rsfd_pkg::IDLE_MAX) begin
                idle_count_nxt = idle_inc;
              end
              if (frame_end) begin
                byte_count_nxt = 8'd0;
                if ((byte_count_r == rsfd_pkg::FRAME_LEN) &&
                    (first_byte == rsfd_pkg::START_BYTE)) begin
                  state_nxt = ST_UNPACK;
                  ch_nxt    = '0;
                end
              end
            end
            rsfd_pkg::CMD_READ: begin
              out_valid_nxt = 1'b1;
              out_value_nxt = rd_ok ? chan_store_r[rd_idx[CH_W-1:0]] : 11'd0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_UNPACK: begin
        fb_ctrl.shift = 1'b1;
        ch_nxt        = ch_r + 1'b1;
        if (ch_r == CH_W'(NUM_CHANNELS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      idle_ticks_r <= rsfd_pkg::IDLE_TICKS_RST;
      byte_count_r <= 8'd0;
      idle_count_r <= 8'd0;
      ch_r         <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_store_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      byte_count_r <= byte_count_nxt;
      idle_count_r <= idle_count_nxt;
      ch_r         <= ch_nxt;
      out_valid_r  <= out_valid_nxt;
      if (state_r == ST_UNPACK) begin
        chan_store_r[ch_r] <= chan_bits;
      end
    end
    out_value_r <= out_value_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_channel_value = out_value_r;

  // checks
  `RSFD_ASSERT_NOW(a_busy_stalls, state_r == ST_UNPACK, in_stall)
  `RSFD_ASSERT_NOW(a_ch_range, state_r == ST_UNPACK, ch_r <= CH_W'(NUM_CHANNELS - 1))
  `RSFD_ASSERT_NEXT(a_read_result, accept && (in_cmd == rsfd_pkg::CMD_READ), out_valid)
  `RSFD_ASSERT_NEXT(a_frame_end_clears, frame_end, byte_count_r == 8'd0)

endmodule
